### src/lsn_pkg.sv
// ----------------------------------------------------------------------------
// lsn_pkg
// Shared widths, codes, weights and sequencer states for the line sensor
// normalizer and centroid block.
// ----------------------------------------------------------------------------
package lsn_pkg;

	// scan geometry
	localparam int CHANNELS = 8;
	localparam int CH_W     = $clog2(CHANNELS);

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 8;
	localparam int POS_W    = 15;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 48;

	// datapath widths: sum of six levels, signed weighted sum, divider
	localparam int SUM_W = 11;
	localparam int ACC_W = 24;
	localparam int QUO_W = 14;
	localparam int DVD_W = 23;
	localparam int CNT_W = 4;
	localparam int WGT_W = 15;
	localparam int TAP_W = 3;

	// divider step counts (quotient bits needed by each division)
	localparam int NDIV_STEPS = 8;
	localparam int CDIV_STEPS = 14;
	localparam int TAPS       = 6;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_MODE = 2'd1;

	// capture mode codes
	localparam logic [1:0] CAP_RUN   = 2'd0;
	localparam logic [1:0] CAP_WHITE = 2'd1;
	localparam logic [1:0] CAP_BLACK = 2'd2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd70;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'd255;

	// centroid weights of channels 1..6
	function automatic logic signed [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
		logic signed [WGT_W-1:0] w;
		case (k)
			3'd0:    w = -15'sd10000;
			3'd1:    w = -15'sd6000;
			3'd2:    w = -15'sd2000;
			3'd3:    w = 15'sd2000;
			3'd4:    w = 15'sd6000;
			3'd5:    w = 15'sd10000;
			default: w = '0;
		endcase
		return w;
	endfunction

	// sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CAL  = 8'b0000_0010,
		ST_NDIV = 8'b0000_0100,
		ST_LVL  = 8'b0000_1000,
		ST_MAC  = 8'b0001_0000,
		ST_CSET = 8'b0010_0000,
		ST_CDIV = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

endpackage

### src/line_sensor_normalize_and_centroid.sv
// ----------------------------------------------------------------------------
// line_sensor_normalize_and_centroid
// Median filter, calibrated normalization, line mask and weighted centroid
// for a round-robin scan of infrared line sensor channels.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one request per channel scan step: three 12-bit
//   conversions of the current channel; channels are taken in turn 0..7.
// - m_axis returns one result per request: channel, raw level, normalized
//   level, line mask and the signed centroid position of channels 1..6.
// - cfg_wen/cfg_index/cfg_wdata write threshold (index 0) and capture mode
//   (index 1); write only while no request is in flight.
// - From input accept to result valid a request passes a calibration step,
//   8 steps of the shared restoring divider for the level, a 6-step
//   multiply-accumulate over the stored levels, 14 divider steps for the
//   centroid, plus set-up and output states. Clamped levels and an empty
//   centroid skip their division.
// - One request is worked on at a time; s_axis_tready is high only while
//   the sequencer waits for input.
// - The result sits in an output register: the next request is taken while
//   it waits, and a finished result holds in the last step until the
//   register is free.
// - Reset clears calibration levels, stored levels, the mask and the
//   channel counter, and loads the threshold with 70.
// ----------------------------------------------------------------------------
module line_sensor_normalize_and_centroid (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_wen,
	input  logic [lsn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lsn_pkg::IN_W-1:0]        s_axis_tdata,  // sample_a, sample_b, sample_c
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lsn_pkg::OUT_W-1:0]       m_axis_tdata   // channel, raw_level,
	                                                       // normalized_level, line_mask,
	                                                       // position
);
	import lsn_pkg::*;

	state_t state_q;

	logic [LEVEL_W-1:0]    thr_q;
	logic [1:0]            mode_q;
	logic [CH_W-1:0]       ch_q;
	logic [LEVEL_W-1:0]    white_q [CHANNELS];
	logic [LEVEL_W-1:0]    black_q [CHANNELS];
	logic [LEVEL_W-1:0]    level_q [CHANNELS];
	logic [CHANNELS-1:0]   mask_q;

	logic [LEVEL_W-1:0]    raw_q;
	logic [LEVEL_W-1:0]    lvl_q;
	logic [SUM_W-1:0]      rem_q;
	logic [SUM_W-1:0]      div_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [QUO_W-1:0]      quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TAP_W-1:0]      tap_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  neg_q;
	logic signed [POS_W-1:0] pos_q;

	logic                  in_acc;
	logic                  out_load;
	logic [LEVEL_W-1:0]    sa, sb, sc, med;

	// input accept and output register load
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

	// median of the three conversions, each reduced to 8 bits
	always_comb begin
		sa = s_axis_tdata[SAMPLE_W-1:SAMPLE_W-LEVEL_W];
		sb = s_axis_tdata[2*SAMPLE_W-1:2*SAMPLE_W-LEVEL_W];
		sc = s_axis_tdata[3*SAMPLE_W-1:3*SAMPLE_W-LEVEL_W];
		if ((sa >= sb && sb >= sc) || (sc >= sb && sb >= sa)) begin
			med = sb;
		end else if ((sb >= sa && sa >= sc) || (sc >= sa && sa >= sb)) begin
			med = sa;
		end else begin
			med = sc;
		end
	end

	// calibration levels after this cycle's capture
	logic                  cap_w, cap_b;
	logic [LEVEL_W-1:0]    wht_eff, blk_eff, span, diff;
	logic [2*LEVEL_W-1:0]  ndvd;

	always_comb begin
		cap_w   = (mode_q == CAP_WHITE) && (raw_q > white_q[ch_q]);
		cap_b   = (mode_q == CAP_BLACK) && (raw_q > black_q[ch_q]);
		wht_eff = cap_w ? raw_q : white_q[ch_q];
		blk_eff = cap_b ? raw_q : black_q[ch_q];
		span    = wht_eff - blk_eff;
		diff    = raw_q - blk_eff;
		// 255 * diff
		ndvd    = {diff, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, diff};
	end

	// shared restoring divider step
	logic [SUM_W:0]        trial;
	logic                  ge;
	logic [SUM_W-1:0]      rem_nx;
	logic [QUO_W-1:0]      quo_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[DVD_W-1]};
		ge     = trial >= {1'b0, div_q};
		rem_nx = ge ? SUM_W'(trial - {1'b0, div_q}) : trial[SUM_W-1:0];
		quo_nx = {quo_q[QUO_W-2:0], ge};
	end

	// weighted tap product and centroid operand
	logic [CH_W-1:0]           tap_idx;
	logic signed [ACC_W-1:0]   prod;
	logic [ACC_W-1:0]          mag;
	logic [QUO_W:0]            qpos;

	always_comb begin
		tap_idx = CH_W'(tap_q) + CH_W'(1);
		prod    = ACC_W'(tap_weight(tap_q)) * ACC_W'($signed({1'b0, level_q[tap_idx]}));
		mag     = (acc_q < 0) ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		qpos    = {1'b0, quo_nx};
	end

	// sequencer, configuration and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			thr_q         <= THRESHOLD_RESET;
			mode_q        <= CAP_RUN;
			ch_q          <= '0;
			mask_q        <= '0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				white_q[i] <= '0;
				black_q[i] <= '0;
				level_q[i] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_THRESHOLD:    thr_q  <= cfg_wdata[LEVEL_W-1:0];
					REG_CAPTURE_MODE: mode_q <= cfg_wdata[1:0];
					default:          ;
				endcase
			end

			// output valid: set on load, cleared when taken
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CAL;
					end
				end
				ST_CAL: begin
					if (cap_w) begin
						white_q[ch_q] <= raw_q;
					end
					if (cap_b) begin
						black_q[ch_q] <= raw_q;
					end
					if (raw_q < blk_eff || raw_q > wht_eff || span == '0) begin
						state_q <= ST_LVL;
					end else begin
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					level_q[ch_q] <= lvl_q;
					mask_q[ch_q]  <= (lvl_q > thr_q);
					state_q       <= ST_MAC;
				end
				ST_MAC: begin
					if (tap_q == TAP_W'(TAPS - 1)) begin
						state_q <= ST_CSET;
					end
				end
				ST_CSET: begin
					state_q <= (sum_q == '0) ? ST_OUT : ST_CDIV;
				end
				ST_CDIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						ch_q    <= (ch_q == CH_W'(CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					raw_q <= med;
				end
			end
			ST_CAL: begin
				if (raw_q < blk_eff) begin
					lvl_q <= '0;
				end else if (raw_q > wht_eff) begin
					lvl_q <= LEVEL_MAX;
				end else if (span == '0) begin
					lvl_q <= '0;
				end
				// quotient is below 256, so the top byte starts as remainder
				rem_q <= SUM_W'(ndvd[2*LEVEL_W-1:LEVEL_W]);
				dvd_q <= {ndvd[LEVEL_W-1:0], {(DVD_W-LEVEL_W){1'b0}}};
				div_q <= SUM_W'(span);
				quo_q <= '0;
				cnt_q <= CNT_W'(NDIV_STEPS - 1);
			end
			ST_NDIV, ST_CDIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				quo_q <= quo_nx;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					if (state_q == ST_NDIV) begin
						lvl_q <= quo_nx[LEVEL_W-1:0];
					end else begin
						pos_q <= neg_q ? POS_W'(-$signed(qpos)) : POS_W'($signed(qpos));
					end
				end
			end
			ST_LVL: begin
				acc_q <= '0;
				sum_q <= '0;
				tap_q <= '0;
			end
			ST_MAC: begin
				acc_q <= acc_q + prod;
				sum_q <= sum_q + SUM_W'(level_q[tap_idx]);
				tap_q <= tap_q + TAP_W'(1);
			end
			ST_CSET: begin
				// centroid magnitude stays below 2^14 times the level sum
				neg_q <= (acc_q < 0);
				pos_q <= '0;
				rem_q <= SUM_W'(mag[DVD_W-1:CDIV_STEPS]);
				dvd_q <= {mag[CDIV_STEPS-1:0], {(DVD_W-CDIV_STEPS){1'b0}}};
				div_q <= sum_q;
				quo_q <= '0;
				cnt_q <= CNT_W'(CDIV_STEPS - 1);
			end
			ST_OUT: begin
				if (out_load) begin
					m_axis_tdata <= {{(OUT_W - POS_W - 3*LEVEL_W - 3){1'b0}},
						pos_q, mask_q[LEVEL_W-1:0], lvl_q, raw_q, ch_q[2:0]};
				end
			end
			default: ;
		endcase
	end

	// divider never runs on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NDIV || state_q == ST_CDIV) |-> (div_q != '0))
		else $error("divider started with zero divisor");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NDIV || state_q == ST_CDIV) |-> (rem_q < div_q))
		else $error("divider remainder out of range");

	// one request in flight at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input taken while busy");

	// line bit of the finished channel matches its level
	a_mask_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (mask_q[ch_q] == (lvl_q > thr_q)))
		else $error("line mask bit disagrees with level");

endmodule
